@@ design/rbli_pkg.sv @@
package rbli_pkg;

  // stored list capacity
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

  // open-ended response bound and its stand-in while comparing
  localparam logic signed [15:0] RESP_OPEN = -16'sd1;
  localparam logic signed [15:0] RESP_HIGH = 16'sd20000;

  // request kinds carried on tuser
  localparam logic [1:0] MODE_QUERY = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // one box, first field in the highest bits
  typedef struct packed {
    logic signed [15:0] resp_hi;
    logic signed [15:0] resp_lo;
    logic        [15:0] item_hi;
    logic        [15:0] item_lo;
  } box_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FETCH  = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  // open-ended bound maps to the high stand-in
  function automatic logic signed [15:0] open_to_high(input logic signed [15:0] r);
    return (r == RESP_OPEN) ? RESP_HIGH : r;
  endfunction

  // high stand-in maps back to open-ended
  function automatic logic signed [15:0] high_to_open(input logic signed [15:0] r);
    return (r == RESP_HIGH) ? RESP_OPEN : r;
  endfunction

endpackage

@@ design/range_box_list_intersect.sv @@
// Box list intersection. A request of kind load (tuser 1) appends a box to the
// stored list, up to rbli_pkg::LIST_DEPTH boxes, further loads are dropped; kind
// clear (tuser 2) empties the list; kind 3 is dropped. None of these gives a
// result; tready stays high. A query (tuser 0) is intersected with every stored
// box, oldest first, and each non-empty intersection comes out as one result
// with tuser (hit) set; a response bound of -1 is open-ended, compared as 20000
// and given back as -1. The final result of a query has tlast set; a query that
// meets nothing gives a single result with hit clear, zero data and tlast set.
// A query steps from the accept through a fetch and a check per stored box, as
// the one compare unit is fed from the one read port of the list memory, to a
// closing step; a waiting output stretches that. s_axis_tready is low for the
// whole of a query. One result is held back until the next hit or the end of
// the scan, so that tlast can be placed on the right one.
module range_box_list_intersect (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // item_lo, item_hi, resp_lo, resp_hi
  input  logic [1:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // out_item_lo, out_item_hi, out_resp_lo, out_resp_hi
  output logic        m_axis_tuser,   // hit
  output logic        m_axis_tlast    // last
);

  localparam int unsigned IDX_W = rbli_pkg::IDX_W;
  localparam int unsigned CNT_W = rbli_pkg::CNT_W;

  rbli_pkg::state_e state_q, state_d;

  // stored list
  rbli_pkg::box_t mem_q [rbli_pkg::LIST_DEPTH];
  rbli_pkg::box_t rdata_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  // query box, response bounds already in compare form
  rbli_pkg::box_t qry_q;

  // held-back hit
  logic           pend_v_q, pend_v_d;
  rbli_pkg::box_t pend_q, pend_d;

  // output register
  logic           out_v_q, out_v_d;
  rbli_pkg::box_t out_q, out_d;
  logic           out_hit_q, out_hit_d;
  logic           out_last_q, out_last_d;

  logic in_req;
  logic out_free;
  logic load_en;
  logic last_entry;

  // shared compare unit
  logic        [15:0] cmp_ilo, cmp_ihi;
  logic signed [15:0] cmp_rlo, cmp_rhi, s_rlo, s_rhi;
  logic               cmp_hit;

  assign s_axis_tready = (state_q == rbli_pkg::ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;
  assign load_en       = in_req && (s_axis_tuser == rbli_pkg::MODE_LOAD)
                         && (count_q < CNT_W'(rbli_pkg::LIST_DEPTH));
  assign last_entry    = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    s_rlo   = rbli_pkg::open_to_high(rdata_q.resp_lo);
    s_rhi   = rbli_pkg::open_to_high(rdata_q.resp_hi);
    cmp_ilo = (qry_q.item_lo > rdata_q.item_lo) ? qry_q.item_lo : rdata_q.item_lo;
    cmp_ihi = (qry_q.item_hi < rdata_q.item_hi) ? qry_q.item_hi : rdata_q.item_hi;
    cmp_rlo = (qry_q.resp_lo > s_rlo) ? qry_q.resp_lo : s_rlo;
    cmp_rhi = (qry_q.resp_hi < s_rhi) ? qry_q.resp_hi : s_rhi;
    cmp_hit = (cmp_ihi >= cmp_ilo) && (cmp_rhi >= cmp_rlo);
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q && !m_axis_tready;
    out_d      = out_q;
    out_hit_d  = out_hit_q;
    out_last_d = out_last_q;

    case (state_q)
      rbli_pkg::ST_IDLE: begin
        if (in_req) begin
          case (s_axis_tuser)
            rbli_pkg::MODE_QUERY: begin
              idx_d    = '0;
              pend_v_d = 1'b0;
              state_d  = (count_q == '0) ? rbli_pkg::ST_FINISH : rbli_pkg::ST_FETCH;
            end
            rbli_pkg::MODE_LOAD: begin
              if (load_en) count_d = count_q + CNT_W'(1);
            end
            rbli_pkg::MODE_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      rbli_pkg::ST_FETCH: begin
        // memory read of idx_q lands in rdata_q
        state_d = rbli_pkg::ST_CHECK;
      end
      rbli_pkg::ST_CHECK: begin
        // a new hit pushes the held one out, so wait for room
        if (!(cmp_hit && pend_v_q && !out_free)) begin
          if (cmp_hit) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_d      = pend_q;
              out_hit_d  = 1'b1;
              out_last_d = 1'b0;
            end
            pend_v_d        = 1'b1;
            pend_d.item_lo  = cmp_ilo;
            pend_d.item_hi  = cmp_ihi;
            pend_d.resp_lo  = rbli_pkg::high_to_open(cmp_rlo);
            pend_d.resp_hi  = rbli_pkg::high_to_open(cmp_rhi);
          end
          if (last_entry) begin
            state_d = rbli_pkg::ST_FINISH;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = rbli_pkg::ST_FETCH;
          end
        end
      end
      rbli_pkg::ST_FINISH: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = pend_v_q ? pend_q : '0;
          out_hit_d  = pend_v_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = rbli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rbli_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rbli_pkg::ST_IDLE;
      count_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_hit_q  <= out_hit_d;
    out_last_q <= out_last_d;
    if (in_req && (s_axis_tuser == rbli_pkg::MODE_QUERY)) begin
      qry_q.item_lo <= s_axis_tdata[15:0];
      qry_q.item_hi <= s_axis_tdata[31:16];
      qry_q.resp_lo <= rbli_pkg::open_to_high(s_axis_tdata[47:32]);
      qry_q.resp_hi <= rbli_pkg::open_to_high(s_axis_tdata[63:48]);
    end
  end

  // list memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      mem_q[count_q[IDX_W-1:0]] <= s_axis_tdata;
    end
    rdata_q <= mem_q[idx_q];
  end

  // a miss result always closes the query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_hit_q) |-> out_last_q)
    else $error("miss result without last");

  // a miss result carries no box
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_hit_q) |-> (out_q == '0))
    else $error("miss result with data");

  // list never grows past its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(rbli_pkg::LIST_DEPTH))
    else $error("stored count overflow");

  // no held-back hit survives the end of a query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbli_pkg::ST_IDLE) |-> !pend_v_q)
    else $error("held result left behind");

endmodule

@@ dv/range_box_list_intersect_test.sv @@
module range_box_list_intersect_test;
  timeunit 1ns;
  timeprecision 1ps;

  // the one request kind with no name in the package, dropped by the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // receiver hold-off, long enough to stall the input behind a full output
  localparam int HOLD_CYCLES = 300;
  // a full scan of the list plus some margin
  localparam int TAIL_CYCLES = 2 * rbli_pkg::LIST_DEPTH + 10;
  localparam int RANDOM_ITEMS = 200;

  // one expected or observed result
  typedef struct packed {
    logic           hit;
    rbli_pkg::box_t box;
    logic           last;
  } isect_t;

  // predicts every query against its own copy of the stored list
  class isect_scoreboard;
    rbli_pkg::box_t stored[rbli_pkg::LIST_DEPTH];
    int unsigned    stored_count;
    isect_t         expected_q[$];
    int unsigned    errors;
    int unsigned    queries, loads, dropped_loads, clears, ignored;
    int unsigned    results_seen, hits_seen;

    // open-ended bound stands for the high value while comparing
    function int compare_bound(logic signed [15:0] r);
      return (r == rbli_pkg::RESP_OPEN) ? int'(rbli_pkg::RESP_HIGH) : int'(r);
    endfunction

    // and comes back as open-ended
    function logic signed [15:0] output_bound(int r);
      return (r == int'(rbli_pkg::RESP_HIGH)) ? rbli_pkg::RESP_OPEN : 16'(r);
    endfunction

    function void note_request(logic [1:0] mode, rbli_pkg::box_t q);
      isect_t found[$];
      isect_t r;
      int ilo, ihi, rlo, rhi, a, b;
      case (mode)
        rbli_pkg::MODE_LOAD: begin
          if (stored_count < rbli_pkg::LIST_DEPTH) begin
            stored[stored_count] = q;
            stored_count++;
            loads++;
          end else begin
            dropped_loads++;
          end
        end
        rbli_pkg::MODE_CLEAR: begin
          stored_count = 0;
          clears++;
        end
        rbli_pkg::MODE_QUERY: begin
          queries++;
          for (int k = 0; k < stored_count; k++) begin
            a   = int'(q.item_lo);
            b   = int'(stored[k].item_lo);
            ilo = (a > b) ? a : b;
            a   = int'(q.item_hi);
            b   = int'(stored[k].item_hi);
            ihi = (a < b) ? a : b;
            if (ihi < ilo) continue;
            a   = compare_bound(q.resp_lo);
            b   = compare_bound(stored[k].resp_lo);
            rlo = (a > b) ? a : b;
            a   = compare_bound(q.resp_hi);
            b   = compare_bound(stored[k].resp_hi);
            rhi = (a < b) ? a : b;
            if (rhi < rlo) continue;
            r.hit         = 1'b1;
            r.box.item_lo = 16'(ilo);
            r.box.item_hi = 16'(ihi);
            r.box.resp_lo = output_bound(rlo);
            r.box.resp_hi = output_bound(rhi);
            r.last        = 1'b0;
            found.push_back(r);
          end
          if (found.size() == 0) begin
            // a miss: one empty result closing the query
            r      = '0;
            r.last = 1'b1;
            found.push_back(r);
          end else begin
            r      = found.pop_back();
            r.last = 1'b1;
            found.push_back(r);
          end
          foreach (found[i]) expected_q.push_back(found[i]);
        end
        default: ignored++;
      endcase
    endfunction

    function void check_result(logic hit, logic [63:0] data, logic last);
      isect_t         e;
      rbli_pkg::box_t got;
      got = rbli_pkg::box_t'(data);
      results_seen++;
      if (hit) hits_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: hit %0d data %h last %0d", hit, data, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (hit !== e.hit) begin
        $error("hit: expected %0d, actual %0d", e.hit, hit);
        errors++;
      end
      if (got.item_lo !== e.box.item_lo) begin
        $error("out_item_lo: expected %0d, actual %0d", e.box.item_lo, got.item_lo);
        errors++;
      end
      if (got.item_hi !== e.box.item_hi) begin
        $error("out_item_hi: expected %0d, actual %0d", e.box.item_hi, got.item_hi);
        errors++;
      end
      if (got.resp_lo !== e.box.resp_lo) begin
        $error("out_resp_lo: expected %0d, actual %0d", e.box.resp_lo, got.resp_lo);
        errors++;
      end
      if (got.resp_hi !== e.box.resp_hi) begin
        $error("out_resp_hi: expected %0d, actual %0d", e.box.resp_hi, got.resp_hi);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;    // item_lo, item_hi, resp_lo, resp_hi
  logic [1:0]  s_axis_tuser;    // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;    // out_item_lo, out_item_hi, out_resp_lo, out_resp_hi
  logic        m_axis_tuser;    // hit
  logic        m_axis_tlast;    // last

  isect_scoreboard sb;

  // idling controls, set by the stimulus per round
  bit tx_steady;
  bit rx_steady;
  bit hold_req;
  int unsigned items_sent;

  range_box_list_intersect u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // both handshakes sampled at the rising edge, stimulus moves at the falling one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tuser, rbli_pkg::box_t'(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end
    end
  end

  // offer one request after a random gap and hold it until it is taken
  task automatic send_request(input logic [1:0] mode, input rbli_pkg::box_t b);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = mode;
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // drop valid once the last offered request has gone in
  task automatic quiet_sender();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // sender pause: nothing more until every predicted result has come out
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic rbli_pkg::box_t mk_box(int ilo, int ihi, int rlo, int rhi);
    rbli_pkg::box_t b;
    b.item_lo = 16'(ilo);
    b.item_hi = 16'(ihi);
    b.resp_lo = 16'(rlo);
    b.resp_hi = 16'(rhi);
    return b;
  endfunction

  // response bound: open-ended, the high stand-in, any 16 bits, or in range
  function automatic int pick_resp();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 4) return -1;
    if (sel == 4) return int'(rbli_pkg::RESP_HIGH);
    if (sel == 5) return int'($signed(16'($urandom())));
    if (sel < 13) return $urandom_range(0, 400);
    return $urandom_range(0, 19999);
  endfunction

  // mostly well-formed boxes clustered so that they overlap often
  function automatic rbli_pkg::box_t make_box();
    int scale, ilo, ihi, rlo, rhi, t, clo, chi;
    scale = $urandom_range(0, 3);
    case (scale)
      1: ilo = $urandom_range(0, 65535);
      2: ilo = $urandom_range(65000, 65535);
      default: ilo = $urandom_range(0, 300);
    endcase
    ihi = ilo + $urandom_range(0, (scale == 1) ? 65535 : 300);
    if (ihi > 65535) ihi = 65535;
    // now and then an empty item range
    if ($urandom_range(0, 9) == 0) begin
      t = ilo; ilo = ihi; ihi = t;
    end
    rlo = pick_resp();
    rhi = pick_resp();
    clo = (rlo == -1) ? int'(rbli_pkg::RESP_HIGH) : rlo;
    chi = (rhi == -1) ? int'(rbli_pkg::RESP_HIGH) : rhi;
    if (clo > chi && $urandom_range(0, 9) != 0) begin
      t = rlo; rlo = rhi; rhi = t;
    end
    return mk_box(ilo, ihi, rlo, rhi);
  endfunction

  // receiver: random gap per result, plus one long hold-off on request
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
          m_axis_tready = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // main stimulus
  initial begin
    int round, kind, n;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = rbli_pkg::MODE_QUERY;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    hold_req      = 1'b0;
    items_sent    = 0;
    round         = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: query on an empty list, then the unused kind with every bit set
    send_request(rbli_pkg::MODE_QUERY, mk_box(0, 0, 0, 0));
    send_request(MODE_UNUSED, rbli_pkg::box_t'({64{1'b1}}));
    // stored boxes: whole item span open-ended, plain, high stand-in,
    // empty item range, responses beyond the legal range
    send_request(rbli_pkg::MODE_LOAD, mk_box(0, 65535, -1, -1));
    send_request(rbli_pkg::MODE_LOAD, mk_box(100, 200, 0, 19999));
    send_request(rbli_pkg::MODE_LOAD, mk_box(150, 400, 5000, 20000));
    send_request(rbli_pkg::MODE_LOAD, mk_box(500, 499, 0, 100));
    send_request(rbli_pkg::MODE_LOAD, mk_box(0, 65535, -32768, 32767));
    // queries against them, empty ranges among them
    send_request(rbli_pkg::MODE_QUERY, mk_box(0, 65535, -1, -1));
    send_request(rbli_pkg::MODE_QUERY, mk_box(150, 150, 0, 0));
    send_request(rbli_pkg::MODE_QUERY, mk_box(300, 200, 0, 19999));
    send_request(rbli_pkg::MODE_QUERY, mk_box(65535, 65535, 19999, -1));
    send_request(rbli_pkg::MODE_QUERY, mk_box(120, 160, 7000, 6000));
    // fill past capacity, the last load is dropped
    repeat (12) send_request(rbli_pkg::MODE_LOAD, make_box());
    send_request(rbli_pkg::MODE_QUERY, mk_box(0, 65535, -32768, 32767));
    // clear, then a miss on the emptied list
    send_request(rbli_pkg::MODE_CLEAR, mk_box(0, 0, 0, 0));
    send_request(rbli_pkg::MODE_QUERY, mk_box(0, 65535, -1, -1));
    quiet_sender();
    wait_drained();

    // random rounds: mostly clear, load, query sequences, some noise
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      round++;
      tx_steady = ($urandom_range(0, 5) == 0);
      rx_steady = ($urandom_range(0, 5) == 0);
      if (round % 10 == 5) begin
        quiet_sender();
        wait_drained();
      end
      kind = $urandom_range(0, 4);
      if (round == 8) begin
        // long receiver hold-off over a full list while queries keep coming
        hold_req  = 1'b1;
        tx_steady = 1'b1;
        kind      = 1;
      end
      if (kind == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_request(2'($urandom_range(0, 3)),
                       rbli_pkg::box_t'({$urandom(), $urandom()}));
        end
      end else begin
        if ($urandom_range(0, 3) != 0 || round == 8) begin
          send_request(rbli_pkg::MODE_CLEAR, rbli_pkg::box_t'({$urandom(), $urandom()}));
        end
        if (round == 8) n = rbli_pkg::LIST_DEPTH;
        else if ($urandom_range(0, 7) == 0)
          n = $urandom_range(rbli_pkg::LIST_DEPTH - 2, rbli_pkg::LIST_DEPTH + 2);
        else n = $urandom_range(0, 6);
        repeat (n) send_request(rbli_pkg::MODE_LOAD, make_box());
        n = (round == 8) ? 6 : $urandom_range(1, 4);
        repeat (n) send_request(rbli_pkg::MODE_QUERY, make_box());
      end
    end
    quiet_sender();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d queries, %0d loads (%0d beyond capacity), %0d clears, %0d dropped",
             sb.queries, sb.loads, sb.dropped_loads, sb.clears, sb.ignored);
    $display("checked %0d results, %0d of them hits, %0d mismatches",
             sb.results_seen, sb.hits_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
